// ===== rtl/rcs_pkg.sv =====
`default_nettype none

package rcs_pkg;

    // Largest packet, in bytes, unless the top level overrides it.
    localparam int unsigned MAX_PACKET_BYTES_DEFAULT = 1400;

    localparam int SEQ_W  = 31;  // sequence numbers
    localparam int LEN_W  = 11;  // byte lengths on the ports
    localparam int WORD_W = 32;  // header words
    localparam int PORT_W = 16;  // port identifier
    localparam int SIZE_W = 17;  // internal byte arithmetic, holds any packet limit

    localparam logic [SIZE_W-1:0] HDR_BYTES  = SIZE_W'(8);
    localparam logic [SIZE_W-1:0] PORT_BYTES = SIZE_W'(2);
    localparam logic [SIZE_W-1:0] LEN_MAX    = SIZE_W'((1 << LEN_W) - 1);

    typedef enum logic
    {
        CMD_TRANSMIT = 1'b0,
        CMD_RECEIVE  = 1'b1
    } cmd_t;

    typedef enum logic [1:0]
    {
        ST_SENT      = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_ACCEPTED  = 2'd2,
        ST_DISCARDED = 2'd3
    } status_t;

    typedef enum logic
    {
        REG_IS_CLIENT     = 1'b0,
        REG_LOCAL_PORT_ID = 1'b1
    } reg_idx_t;

    typedef struct packed
    {
        logic              is_client;
        logic [PORT_W-1:0] local_port_id;
    } cfg_t;

    typedef struct packed
    {
        logic              command;
        logic [LEN_W-1:0]  unreliable_length;
        logic [LEN_W-1:0]  pending_length;
        logic              overflowed;
        logic [WORD_W-1:0] seq_word;
        logic [WORD_W-1:0] ack_word;
    } item_t;

    typedef struct packed
    {
        status_t           status;
        logic [WORD_W-1:0] header_first;
        logic [WORD_W-1:0] header_second;
        logic [PORT_W-1:0] port_field;
        logic              sends_reliable;
        logic [LEN_W-1:0]  reliable_bytes;
        logic              unreliable_fits;
        logic              pending_taken;
        logic [LEN_W-1:0]  packet_bytes;
        logic [SEQ_W-1:0]  dropped_count;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/rcs_if.sv =====
`default_nettype none

interface rcs_in_if;
    logic                       valid;
    logic                       ready;
    logic                       command;
    logic [rcs_pkg::LEN_W-1:0]  unreliable_length;
    logic [rcs_pkg::LEN_W-1:0]  pending_length;
    logic                       overflowed;
    logic [rcs_pkg::WORD_W-1:0] seq_word;
    logic [rcs_pkg::WORD_W-1:0] ack_word;

    modport source
    (
        output valid, command, unreliable_length, pending_length, overflowed,
               seq_word, ack_word,
        input  ready
    );

    modport sink
    (
        input  valid, command, unreliable_length, pending_length, overflowed,
               seq_word, ack_word,
        output ready
    );
endinterface

interface rcs_out_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 status;
    logic [rcs_pkg::WORD_W-1:0] header_first;
    logic [rcs_pkg::WORD_W-1:0] header_second;
    logic [rcs_pkg::PORT_W-1:0] port_field;
    logic                       sends_reliable;
    logic [rcs_pkg::LEN_W-1:0]  reliable_bytes;
    logic                       unreliable_fits;
    logic                       pending_taken;
    logic [rcs_pkg::LEN_W-1:0]  packet_bytes;
    logic [rcs_pkg::SEQ_W-1:0]  dropped_count;

    modport source
    (
        output valid, status, header_first, header_second, port_field,
               sends_reliable, reliable_bytes, unreliable_fits, pending_taken,
               packet_bytes, dropped_count,
        input  ready
    );

    modport sink
    (
        input  valid, status, header_first, header_second, port_field,
               sends_reliable, reliable_bytes, unreliable_fits, pending_taken,
               packet_bytes, dropped_count,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/rcs_engine.sv =====
`default_nettype none

// Channel state plus the single-pass transmit/receive logic.
module rcs_engine #(
    parameter int unsigned MAX_PACKET_BYTES = rcs_pkg::MAX_PACKET_BYTES_DEFAULT
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire rcs_pkg::item_t   item,
    input  wire rcs_pkg::cfg_t    cfg,
    output rcs_pkg::result_t      result
);

    localparam logic [rcs_pkg::SIZE_W-1:0] MAX_BYTES = rcs_pkg::SIZE_W'(MAX_PACKET_BYTES);

    logic [rcs_pkg::SEQ_W-1:0] oseq_reg, oseq_next;
    logic [rcs_pkg::SEQ_W-1:0] iseq_reg, iseq_next;
    logic [rcs_pkg::SEQ_W-1:0] iack_reg, iack_next;
    logic                      irack_reg, irack_next;
    logic                      irb_reg, irb_next;
    logic                      orb_reg, orb_next;
    logic [rcs_pkg::SEQ_W-1:0] lrs_reg, lrs_next;
    logic [rcs_pkg::LEN_W-1:0] rlen_reg, rlen_next;

    always_comb
    begin
        logic                       send;
        logic                       taken;
        logic [rcs_pkg::LEN_W-1:0]  rlen_eff;
        logic [rcs_pkg::SIZE_W-1:0] used;
        logic [rcs_pkg::SIZE_W-1:0] room;
        logic [rcs_pkg::SIZE_W-1:0] ulen;
        logic [rcs_pkg::SIZE_W-1:0] total;
        logic                       fits;
        logic [rcs_pkg::SEQ_W-1:0]  oseq_inc;
        logic [rcs_pkg::SEQ_W-1:0]  seq;
        logic [rcs_pkg::SEQ_W-1:0]  ack;

        oseq_next  = oseq_reg;
        iseq_next  = iseq_reg;
        iack_next  = iack_reg;
        irack_next = irack_reg;
        irb_next   = irb_reg;
        orb_next   = orb_reg;
        lrs_next   = lrs_reg;
        rlen_next  = rlen_reg;
        result     = '0;

        oseq_inc = oseq_reg + 1'b1;
        seq      = item.seq_word[rcs_pkg::SEQ_W-1:0];
        ack      = item.ack_word[rcs_pkg::SEQ_W-1:0];
        ulen     = rcs_pkg::SIZE_W'(item.unreliable_length);

        // resend when the peer has seen a later packet but not our reliable bit
        send  = (iack_reg > lrs_reg) && (irack_reg != orb_reg);
        taken = (rlen_reg == '0) && (item.pending_length != '0);
        if (taken)
        begin
            send = 1'b1;
        end
        rlen_eff = taken ? item.pending_length : rlen_reg;

        used = rcs_pkg::HDR_BYTES
             + (cfg.is_client ? rcs_pkg::PORT_BYTES : '0)
             + (send ? rcs_pkg::SIZE_W'(rlen_eff) : '0);
        room  = MAX_BYTES - used;
        fits  = (used <= MAX_BYTES) && (room >= ulen);
        total = used + (fits ? ulen : '0);

        case (rcs_pkg::cmd_t'(item.command))
            rcs_pkg::CMD_TRANSMIT:
            begin
                if (item.overflowed)
                begin
                    result.status = rcs_pkg::ST_OVERFLOW;
                end
                else
                begin
                    result.status          = rcs_pkg::ST_SENT;
                    result.header_first    = {send, oseq_reg};
                    result.header_second   = {irb_reg, iseq_reg};
                    result.port_field      = cfg.is_client ? cfg.local_port_id : '0;
                    result.sends_reliable  = send;
                    result.reliable_bytes  = send ? rlen_eff : '0;
                    result.unreliable_fits = fits;
                    result.pending_taken   = taken;
                    result.packet_bytes    = (total > rcs_pkg::LEN_MAX) ? '1
                                           : total[rcs_pkg::LEN_W-1:0];
                    oseq_next = oseq_inc;
                    rlen_next = rlen_eff;
                    if (taken)
                    begin
                        orb_next = ~orb_reg;
                    end
                    if (send)
                    begin
                        lrs_next = oseq_inc;
                    end
                end
            end
            rcs_pkg::CMD_RECEIVE:
            begin
                if (seq <= iseq_reg)
                begin
                    result.status = rcs_pkg::ST_DISCARDED;
                end
                else
                begin
                    result.status        = rcs_pkg::ST_ACCEPTED;
                    result.dropped_count = seq - iseq_reg - 1'b1;
                    if (item.ack_word[rcs_pkg::WORD_W-1] == orb_reg)
                    begin
                        rlen_next = '0;
                    end
                    iseq_next  = seq;
                    iack_next  = ack;
                    irack_next = item.ack_word[rcs_pkg::WORD_W-1];
                    irb_next   = irb_reg ^ item.seq_word[rcs_pkg::WORD_W-1];
                end
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oseq_reg  <= rcs_pkg::SEQ_W'(1);
            iseq_reg  <= '0;
            iack_reg  <= '0;
            irack_reg <= 1'b0;
            irb_reg   <= 1'b0;
            orb_reg   <= 1'b0;
            lrs_reg   <= '0;
            rlen_reg  <= '0;
        end
        else if (load)
        begin
            oseq_reg  <= oseq_next;
            iseq_reg  <= iseq_next;
            iack_reg  <= iack_next;
            irack_reg <= irack_next;
            irb_reg   <= irb_next;
            orb_reg   <= orb_next;
            lrs_reg   <= lrs_next;
            rlen_reg  <= rlen_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/reliable_channel_sequencer_top.sv =====
// Channel   Dir   Protocol                 Payload
// item      in    valid/ready, rcs_in_if   command, lengths, overflow, two rx header words
// result    out   valid/ready, rcs_out_if  status, tx headers, port, lengths, drop count
// cfg       in    write enable/index/data  is_client (0), local_port_id (1)
//
// One item per cycle sustained while the result channel is not stalled; an item
// passes the item register, then the engine logic, then the result register.
// The item register advances whenever the result register is empty or being
// drained. While a result is stalled one more item can still be taken into an
// empty item register; once that register is full the input stalls as well.
// rst_n clears both valid flags, the config registers and the channel state.
// Config must be written only while the block is idle; the block does not enforce it.
`default_nettype none

module reliable_channel_sequencer_top #(
    parameter int unsigned MAX_PACKET_BYTES = rcs_pkg::MAX_PACKET_BYTES_DEFAULT
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    rcs_in_if.sink                          item,
    rcs_out_if.source                       result,
    input  wire logic                       cfg_write,
    input  wire logic                       cfg_index,
    input  wire logic [rcs_pkg::PORT_W-1:0] cfg_data
);

    // item register (payload needs no reset)
    logic             item_vld_reg, item_vld_next;
    rcs_pkg::item_t   item_reg;

    // result register
    logic             res_vld_reg, res_vld_next;
    rcs_pkg::result_t res_reg;
    rcs_pkg::result_t res_comb;

    // config registers
    rcs_pkg::cfg_t    cfg_reg, cfg_next;

    logic advance;   // item register moves through the engine this cycle
    logic item_take; // input transfer this cycle

    assign advance    = item_vld_reg && (!res_vld_reg || result.ready);
    assign item.ready = !item_vld_reg || advance;
    assign item_take  = item.valid && item.ready;

    assign item_vld_next = item_take || (item_vld_reg && !advance);
    assign res_vld_next  = advance || (res_vld_reg && !result.ready);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (rcs_pkg::reg_idx_t'(cfg_index))
                rcs_pkg::REG_IS_CLIENT:     cfg_next.is_client     = cfg_data[0];
                rcs_pkg::REG_LOCAL_PORT_ID: cfg_next.local_port_id = cfg_data;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
            res_vld_reg  <= 1'b0;
            cfg_reg      <= '0;
        end
        else
        begin
            item_vld_reg <= item_vld_next;
            res_vld_reg  <= res_vld_next;
            cfg_reg      <= cfg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            item_reg.command           <= item.command;
            item_reg.unreliable_length <= item.unreliable_length;
            item_reg.pending_length    <= item.pending_length;
            item_reg.overflowed        <= item.overflowed;
            item_reg.seq_word          <= item.seq_word;
            item_reg.ack_word          <= item.ack_word;
        end
        if (advance)
        begin
            res_reg <= res_comb;
        end
    end

    // Sequencing state lives in the engine; it updates only on advance.
    rcs_engine #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (advance),
        .item   (item_reg),
        .cfg    (cfg_reg),
        .result (res_comb)
    );

    assign result.valid           = res_vld_reg;
    assign result.status          = res_reg.status;
    assign result.header_first    = res_reg.header_first;
    assign result.header_second   = res_reg.header_second;
    assign result.port_field      = res_reg.port_field;
    assign result.sends_reliable  = res_reg.sends_reliable;
    assign result.reliable_bytes  = res_reg.reliable_bytes;
    assign result.unreliable_fits = res_reg.unreliable_fits;
    assign result.pending_taken   = res_reg.pending_taken;
    assign result.packet_bytes    = res_reg.packet_bytes;
    assign result.dropped_count   = res_reg.dropped_count;

endmodule

`default_nettype wire

// ===== rtl/rcs_checker.sv =====
`default_nettype none

module rcs_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       res_valid,
    input wire logic                       res_ready,
    input wire logic [1:0]                 status,
    input wire logic [rcs_pkg::WORD_W-1:0] header_first,
    input wire logic                       sends_reliable,
    input wire logic [rcs_pkg::LEN_W-1:0]  reliable_bytes,
    input wire logic                       pending_taken,
    input wire logic [rcs_pkg::LEN_W-1:0]  packet_bytes,
    input wire logic [rcs_pkg::SEQ_W-1:0]  dropped_count
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (status == rcs_pkg::ST_OVERFLOW || status == rcs_pkg::ST_DISCARDED)
        |-> header_first == '0 && packet_bytes == '0 && dropped_count == '0
            && !sends_reliable)
        else $error("overflow or discard result carries data");

    a_taken_sends: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && pending_taken |-> sends_reliable && reliable_bytes != '0)
        else $error("queued message taken but not sent");

    a_sent_header: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && status == rcs_pkg::ST_SENT
        |-> header_first[rcs_pkg::WORD_W-1] == sends_reliable
            && packet_bytes >= rcs_pkg::LEN_W'(8) && dropped_count == '0)
        else $error("sent packet header inconsistent");

endmodule

bind reliable_channel_sequencer_top rcs_checker u_rcs_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_valid      (result.valid),
    .res_ready      (result.ready),
    .status         (result.status),
    .header_first   (result.header_first),
    .sends_reliable (result.sends_reliable),
    .reliable_bytes (result.reliable_bytes),
    .pending_taken  (result.pending_taken),
    .packet_bytes   (result.packet_bytes),
    .dropped_count  (result.dropped_count)
);

`default_nettype wire

// ===== verif/reliable_channel_sequencer_top_tb.sv =====
`timescale 1ns / 100ps

// Self-checking bench for the reliable channel sequencer.
// A clocked driver pulls items from pending_items and offers them on the item
// channel. Each transfer runs through channel_outcome, which keeps its own
// copy of the channel state and the config and queues the result it predicts.
// A clocked monitor drains the result channel under random back-pressure and
// compares each result, field by field, with the oldest prediction.
module reliable_channel_sequencer_top_tb;

    localparam int unsigned PACKET_LIMIT   = rcs_pkg::MAX_PACKET_BYTES_DEFAULT;
    localparam int          PHASE_ITEMS    = 115;
    localparam int          SETTLE_CYCLES  = 6;     // two-stage pipe plus margin
    localparam int          WATCHDOG_LIMIT = 2000;  // far longer than any gap from gap_len

    // Sequencing state of one channel end, as the block holds it.
    typedef struct
    {
        bit [rcs_pkg::SEQ_W-1:0] out_seq;        // next outgoing sequence
        bit [rcs_pkg::SEQ_W-1:0] in_seq;         // last accepted incoming sequence
        bit [rcs_pkg::SEQ_W-1:0] in_acked;       // peer's last acknowledged sequence
        bit                      in_rel_acked;   // peer's reliable ack bit
        bit                      in_rel_bit;     // toggles per received reliable message
        bit                      out_rel_bit;    // toggles per new reliable message
        bit [rcs_pkg::SEQ_W-1:0] last_rel_sent;  // sequence after the last reliable send
        bit [rcs_pkg::LEN_W-1:0] rel_len;        // stored reliable message, 0 when empty
    } chan_state_t;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       cfg_write;
    logic                       cfg_index;
    logic [rcs_pkg::PORT_W-1:0] cfg_data;

    rcs_in_if  item_bus ();
    rcs_out_if result_bus ();

    reliable_channel_sequencer_top #(
        .MAX_PACKET_BYTES (PACKET_LIMIT)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_bus),
        .result    (result_bus),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // Config copy used for prediction; only changes while the block is idle.
    bit                       cfg_client;
    bit [rcs_pkg::PORT_W-1:0] cfg_port;

    // live_state tracks transfers as they happen; plan_state runs ahead as
    // items are queued so the stimulus can follow the channel (acks near our
    // sequence, incoming sequences just past the last accepted one).
    chan_state_t live_state;
    chan_state_t plan_state;

    rcs_pkg::item_t   pending_items[$];
    rcs_pkg::result_t awaited_results[$];
    int               errors;
    int               quiet_cycles;

    function automatic void clear_state(output chan_state_t s);
        s = '{default: '0};
        s.out_seq = 1;
    endfunction

    // One channel event: updates the state and returns the result it causes.
    function automatic rcs_pkg::result_t channel_outcome(inout chan_state_t s,
                                                         input rcs_pkg::item_t it);
        rcs_pkg::result_t          r;
        logic                      send;
        logic                      taken;
        logic                      fits;
        int unsigned               used;
        int unsigned               total;
        logic [rcs_pkg::SEQ_W-1:0] rx_seq;

        r      = '0;
        send   = 1'b0;
        taken  = 1'b0;
        rx_seq = it.seq_word[rcs_pkg::SEQ_W-1:0];
        if (it.command == rcs_pkg::CMD_RECEIVE)
        begin
            // stale or repeated sequence: drop, state untouched
            if (rx_seq <= s.in_seq)
                r.status = rcs_pkg::ST_DISCARDED;
            else
            begin
                r.status        = rcs_pkg::ST_ACCEPTED;
                r.dropped_count = rx_seq - s.in_seq - 1'b1;
                // peer echoes our reliable bit -> message delivered
                if (it.ack_word[rcs_pkg::WORD_W-1] == s.out_rel_bit)
                    s.rel_len = '0;
                s.in_seq       = rx_seq;
                s.in_acked     = it.ack_word[rcs_pkg::SEQ_W-1:0];
                s.in_rel_acked = it.ack_word[rcs_pkg::WORD_W-1];
                if (it.seq_word[rcs_pkg::WORD_W-1])
                    s.in_rel_bit = ~s.in_rel_bit;
            end
        end
        else if (it.overflowed)
            r.status = rcs_pkg::ST_OVERFLOW;
        else
        begin
            // resend when the peer acked past our last reliable send without
            // echoing the current reliable bit
            if (s.in_acked > s.last_rel_sent && s.in_rel_acked != s.out_rel_bit)
                send = 1'b1;
            // store empty: take the queued message, new alternating bit
            if (s.rel_len == 0 && it.pending_length != 0)
            begin
                send          = 1'b1;
                taken         = 1'b1;
                s.rel_len     = it.pending_length;
                s.out_rel_bit = ~s.out_rel_bit;
            end
            r.status        = rcs_pkg::ST_SENT;
            r.header_first  = {send, s.out_seq};
            r.header_second = {s.in_rel_bit, s.in_seq};
            s.out_seq       = s.out_seq + 1'b1;

            used = rcs_pkg::HDR_BYTES;
            if (cfg_client)
            begin
                used         = used + rcs_pkg::PORT_BYTES;
                r.port_field = cfg_port;
            end
            if (send)
            begin
                used            = used + s.rel_len;
                s.last_rel_sent = s.out_seq;
            end
            fits  = (used <= PACKET_LIMIT) && (PACKET_LIMIT - used >= it.unreliable_length);
            total = used + (fits ? it.unreliable_length : 0);
            if (total > rcs_pkg::LEN_MAX)
                total = rcs_pkg::LEN_MAX;

            r.sends_reliable  = send;
            r.reliable_bytes  = send ? s.rel_len : '0;
            r.unreliable_fits = fits;
            r.pending_taken   = taken;
            r.packet_bytes    = total[rcs_pkg::LEN_W-1:0];
        end
        return r;
    endfunction

    // Gap lengths: mostly none, some short, a few long, plus gap-free runs.
    function automatic int unsigned gap_len(inout int unsigned calm_left);
        int unsigned pick;

        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 99) < 3)
        begin
            calm_left = $urandom_range(20, 80);
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        else if (pick < 85)
            return $urandom_range(1, 3);
        else if (pick < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void check_field(string field, longint unsigned want,
                                        longint unsigned got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, field, want, got);
        end
    endfunction

    // ---------------------------------------------------------------------
    // Stimulus builders. Every queued item also advances plan_state.
    // Fields a command ignores carry random bits.
    // ---------------------------------------------------------------------
    task automatic queue_item(input rcs_pkg::item_t it);
        rcs_pkg::result_t unused;

        unused = channel_outcome(plan_state, it);
        pending_items.push_back(it);
    endtask

    task automatic queue_transmit(input int unsigned ulen, input int unsigned plen,
                                  input bit overflow);
        rcs_pkg::item_t it;

        it.command           = rcs_pkg::CMD_TRANSMIT;
        it.unreliable_length = rcs_pkg::LEN_W'(ulen);
        it.pending_length    = rcs_pkg::LEN_W'(plen);
        it.overflowed        = overflow;
        it.seq_word          = $urandom;
        it.ack_word          = $urandom;
        queue_item(it);
    endtask

    task automatic queue_receive(input logic [rcs_pkg::WORD_W-1:0] seq_word,
                                 input logic [rcs_pkg::WORD_W-1:0] ack_word);
        rcs_pkg::item_t it;

        it.command           = rcs_pkg::CMD_RECEIVE;
        it.unreliable_length = rcs_pkg::LEN_W'($urandom);
        it.pending_length    = rcs_pkg::LEN_W'($urandom);
        it.overflowed        = 1'($urandom);
        it.seq_word          = seq_word;
        it.ack_word          = ack_word;
        queue_item(it);
    endtask

    // Well-formed packet from the peer: sequence `step` past the last one,
    // acking `lag` behind our next sequence, echoing our reliable bit or not.
    task automatic queue_peer_packet(input int unsigned step, input int unsigned lag,
                                     input bit echo, input bit reliable);
        logic [rcs_pkg::SEQ_W-1:0] seq;
        logic [rcs_pkg::SEQ_W-1:0] ack;
        logic                      ack_bit;

        seq     = plan_state.in_seq + rcs_pkg::SEQ_W'(step);
        ack     = plan_state.out_seq - rcs_pkg::SEQ_W'(lag);
        ack_bit = echo ? plan_state.out_rel_bit : ~plan_state.out_rel_bit;
        queue_receive({reliable, seq}, {ack_bit, ack});
    endtask

    // Unreliable payload that exactly fills the packet, then one byte more.
    task automatic queue_fit_edges();
        int unsigned room;

        room = PACKET_LIMIT - rcs_pkg::HDR_BYTES - (cfg_client ? rcs_pkg::PORT_BYTES : 0);
        queue_transmit(room, 0, 1'b0);
        queue_transmit(room + 1, 0, 1'b0);
    endtask

    task automatic queue_random_traffic(input int count);
        int unsigned pick;
        int unsigned ulen;
        int unsigned plen;

        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 6)
                queue_transmit($urandom_range(0, PACKET_LIMIT),
                               $urandom_range(0, PACKET_LIMIT), 1'b1);
            else if (pick < 50)
            begin
                case ($urandom_range(0, 3))
                    0:       ulen = $urandom_range(0, 64);
                    1:       ulen = $urandom_range(0, PACKET_LIMIT);
                    2:       ulen = $urandom_range(PACKET_LIMIT - 24, PACKET_LIMIT);
                    default: ulen = $urandom_range(0, 700);
                endcase
                pick = $urandom_range(0, 99);
                if (pick < 60)
                    plen = 0;
                else if (pick < 95)
                    plen = ($urandom_range(0, 3) == 0) ? $urandom_range(1, PACKET_LIMIT)
                                                        : $urandom_range(1, 300);
                else
                    plen = $urandom_range(PACKET_LIMIT + 1, rcs_pkg::LEN_MAX);
                queue_transmit(ulen, plen, 1'b0);
            end
            else if (pick < 88)
                queue_peer_packet(($urandom_range(0, 3) == 0) ? $urandom_range(2, 5) : 1,
                                  $urandom_range(0, 3), $urandom_range(0, 99) < 60,
                                  1'($urandom));
            else if (pick < 94)
                // stale or repeated sequence, random flag and ack word
                queue_receive({1'($urandom),
                               rcs_pkg::SEQ_W'($urandom_range(0, plan_state.in_seq))},
                              $urandom);
            else
                // jump ahead with a random ack word
                queue_receive({1'($urandom),
                               rcs_pkg::SEQ_W'(plan_state.in_seq
                                               + $urandom_range(6, 100000))},
                              $urandom);
        end
    endtask

    task automatic write_config(input bit client,
                                input logic [rcs_pkg::PORT_W-1:0] port_id);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= rcs_pkg::REG_IS_CLIENT;
        cfg_data  <= {(rcs_pkg::PORT_W-1)'($urandom), client};   // upper bits are don't-care
        @(posedge clk);
        cfg_index <= rcs_pkg::REG_LOCAL_PORT_ID;
        cfg_data  <= port_id;
        @(posedge clk);
        cfg_write <= 1'b0;
        cfg_client = client;
        cfg_port   = port_id;
    endtask

    // Block idle: no item waiting, no result outstanding, pipe drained.
    task automatic wait_idle();
        while (pending_items.size() != 0 || awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ---------------------------------------------------------------------
    // Item driver: offers pending_items[0], holds it until the transfer,
    // then predicts its result and idles for a random gap.
    // ---------------------------------------------------------------------
    int unsigned send_hold;
    int unsigned send_calm;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_bus.valid             <= 1'b0;
            item_bus.command           <= rcs_pkg::CMD_TRANSMIT;
            item_bus.unreliable_length <= '0;
            item_bus.pending_length    <= '0;
            item_bus.overflowed        <= 1'b0;
            item_bus.seq_word          <= '0;
            item_bus.ack_word          <= '0;
            send_hold = 0;
            send_calm = 0;
        end
        else
        begin
            if (item_bus.valid && item_bus.ready)
            begin
                awaited_results.push_back(channel_outcome(live_state, pending_items.pop_front()));
                send_hold = gap_len(send_calm);
            end
            // an offered item stays put until it transfers
            if (!(item_bus.valid && !item_bus.ready))
            begin
                if (send_hold > 0)
                begin
                    send_hold--;
                    item_bus.valid <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    item_bus.valid             <= 1'b1;
                    item_bus.command           <= pending_items[0].command;
                    item_bus.unreliable_length <= pending_items[0].unreliable_length;
                    item_bus.pending_length    <= pending_items[0].pending_length;
                    item_bus.overflowed        <= pending_items[0].overflowed;
                    item_bus.seq_word          <= pending_items[0].seq_word;
                    item_bus.ack_word          <= pending_items[0].ack_word;
                end
                else
                    item_bus.valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Result monitor: random back-pressure, in-order compare.
    // ---------------------------------------------------------------------
    int unsigned take_stall;
    int unsigned take_calm;

    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        rcs_pkg::result_t got;
        rcs_pkg::result_t want;

        if (!rst_n)
        begin
            result_bus.ready <= 1'b0;
            take_stall = 0;
            take_calm  = 0;
        end
        else
        begin
            if (result_bus.valid && result_bus.ready)
            begin
                got.status          = rcs_pkg::status_t'(result_bus.status);
                got.header_first    = result_bus.header_first;
                got.header_second   = result_bus.header_second;
                got.port_field      = result_bus.port_field;
                got.sends_reliable  = result_bus.sends_reliable;
                got.reliable_bytes  = result_bus.reliable_bytes;
                got.unreliable_fits = result_bus.unreliable_fits;
                got.pending_taken   = result_bus.pending_taken;
                got.packet_bytes    = result_bus.packet_bytes;
                got.dropped_count   = result_bus.dropped_count;
                if (awaited_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, status %0d", $time, got.status);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("status", want.status, got.status);
                    check_field("header_first", want.header_first, got.header_first);
                    check_field("header_second", want.header_second, got.header_second);
                    check_field("port_field", want.port_field, got.port_field);
                    check_field("sends_reliable", want.sends_reliable, got.sends_reliable);
                    check_field("reliable_bytes", want.reliable_bytes, got.reliable_bytes);
                    check_field("unreliable_fits", want.unreliable_fits,
                                got.unreliable_fits);
                    check_field("pending_taken", want.pending_taken, got.pending_taken);
                    check_field("packet_bytes", want.packet_bytes, got.packet_bytes);
                    check_field("dropped_count", want.dropped_count, got.dropped_count);
                end
            end
            if (take_stall > 0)
            begin
                take_stall--;
                result_bus.ready <= 1'b0;
            end
            else
            begin
                result_bus.ready <= 1'b1;
                take_stall = gap_len(take_calm);
            end
        end
    end

    // Watchdog: too long without a transfer while work is outstanding.
    always @(posedge clk)
    begin
        if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready))
            quiet_cycles = 0;
        else if (pending_items.size() != 0 || awaited_results.size() != 0)
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------------
    initial
    begin
        // nonblocking so the async-reset branches see the edge at time 0
        rst_n     <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= rcs_pkg::REG_IS_CLIENT;
        cfg_data  <= '0;
        errors       = 0;
        quiet_cycles = 0;
        cfg_client   = 1'b0;
        cfg_port     = '0;
        clear_state(live_state);
        clear_state(plan_state);
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Server side, reset config. Directed opening.
        queue_transmit(0, 0, 1'b0);                 // bare header
        queue_fit_edges();                          // unreliable fills the packet / one over
        queue_transmit(100, 100, 1'b1);             // overflow: nothing sent
        queue_receive(32'h0000_0000, 32'h0000_0000); // sequence 0 is stale after reset
        queue_transmit(1292, 100, 1'b0);            // take queued message, exact fit
        queue_transmit(5, 50, 1'b0);                // store busy, queue left alone
        queue_transmit(5, 50, 1'b0);
        queue_peer_packet(1, 0, 1'b0, 1'b0);        // acked past it, bit not echoed
        queue_transmit(0, 0, 1'b0);                 // -> resend
        queue_peer_packet(3, 1, 1'b1, 1'b1);        // two lost, delivered, reliable in
        queue_transmit(0, PACKET_LIMIT, 1'b0);      // reliable alone overfills packet
        queue_transmit(1, 0, 1'b0);
        queue_peer_packet(1, 1, 1'b1, 1'b0);
        queue_transmit(5, rcs_pkg::LEN_MAX, 1'b0);  // packet length saturates
        queue_receive(32'hC000_0000, 32'hFFFF_FFFF); // large jump, all-ones ack
        queue_receive(32'h4000_0000, 32'h7FFF_FFFF); // repeat of that sequence
        queue_transmit(0, 0, 1'b0);
        queue_peer_packet(1, 1, 1'b1, 1'b1);
        queue_transmit(PACKET_LIMIT, 0, 1'b0);      // largest payload never fits
        queue_random_traffic(PHASE_ITEMS);
        wait_idle();

        // Client with all-ones port
        write_config(1'b1, 16'hFFFF);
        queue_fit_edges();
        queue_random_traffic(PHASE_ITEMS);
        wait_idle();

        // Back to server, random port (must not appear)
        write_config(1'b0, rcs_pkg::PORT_W'($urandom));
        queue_random_traffic(PHASE_ITEMS);
        wait_idle();

        // Client with port zero
        write_config(1'b1, 16'h0000);
        queue_fit_edges();
        queue_random_traffic(PHASE_ITEMS);
        wait_idle();

        // Client with random port; last item uses the top incoming sequence
        write_config(1'b1, rcs_pkg::PORT_W'($urandom));
        queue_fit_edges();
        queue_random_traffic(PHASE_ITEMS);
        queue_receive(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        wait_idle();

        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== reliable_channel_sequencer_top.f =====
rtl/rcs_pkg.sv
rtl/rcs_if.sv
rtl/rcs_engine.sv
rtl/reliable_channel_sequencer_top.sv
rtl/rcs_checker.sv
verif/reliable_channel_sequencer_top_tb.sv
